[src/marker_frame_checksum_checker_defines.svh]
// ----------------------------------------------------------------------------
// Marker frame checksum checker assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MARKER_FRAME_CHECKSUM_CHECKER_DEFINES_SVH
`define MARKER_FRAME_CHECKSUM_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define MFCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MFCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mfcc_pkg.sv]
// ----------------------------------------------------------------------------
// mfcc_pkg
// Types, codes and the checksum step shared by the checker and its channels.
// ----------------------------------------------------------------------------
package mfcc_pkg;

    localparam logic [7:0] SEED_STATUS  = 8'h4B;
    localparam logic [7:0] SEED_CONTROL = 8'h62;
    localparam logic [7:0] SUM_INIT     = 8'hFF;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_CONTROL = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_MARKER    = 3'd0;
    localparam logic [2:0] REG_HDR_BYTES = 3'd1;
    localparam logic [2:0] REG_LEN_POS   = 3'd2;
    localparam logic [2:0] REG_DIR_POS   = 3'd3;
    localparam logic [2:0] REG_TYPE_POS  = 3'd4;
    localparam logic [2:0] REG_STATUS    = 3'd5;
    localparam logic [2:0] REG_CONTROL   = 3'd6;

    typedef struct packed {
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] frame_kind;
        logic [7:0] frame_type;
        logic [7:0] body_length;
        logic [7:0] calc_sum;
        logic [7:0] recv_sum;
        logic       sum_ok;
    } out_item_t;

    // Shift left, fold the seed in on carry-out, then mix in the byte.
    function automatic logic [7:0] sum_step(input logic [7:0] r, input logic [7:0] seed,
                                            input logic [7:0] b);
        logic [7:0] t;
        t = {r[6:0], 1'b0};
        if (r[7])
        begin
            t = t ^ seed;
        end
        return t ^ b;
    endfunction

endpackage

[src/mfcc_if.sv]
// ----------------------------------------------------------------------------
// mfcc_if
// Valid/ready channels for received bytes and frame results.
// ----------------------------------------------------------------------------
interface mfcc_in_if import mfcc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mfcc_out_if import mfcc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/marker_frame_checksum_checker.sv]
// ----------------------------------------------------------------------------
// marker_frame_checksum_checker
// Hunts for a marker byte, walks header, body and checksum byte, and reports
// one result per frame with both running checksums resolved by direction.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake        payload
//  ---------  ---  ---------------  ------------------------------------------
//  byte_in    in   valid / ready    rx_byte
//  frame_out  out  valid / ready    frame_kind, frame_type, body_length,
//                                   calc_sum, recv_sum, sum_ok
//  apb        in   psel / penable   7 registers at byte address 4*i
//
//  One byte is taken per cycle while byte_in is ready; all per-byte work is one short step from the
//  frame state registers into the next state and the result register.
//  A result appears in the cycle after its checksum byte transfer.
//  byte_in stays ready while a result waits, except for a checksum byte,
//  which holds until the result register is free or drains in the same cycle.
//  rst_n resets the frame state and the result valid flag and loads the registers with their defaults.
//
`include "marker_frame_checksum_checker_defines.svh"

module marker_frame_checksum_checker import mfcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    mfcc_in_if.sink     byte_in,
    mfcc_out_if.source  frame_out
);

    // Frame phases
    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_SUM    = 2'd3;

    // Configuration registers
    logic [7:0] marker_reg;
    logic [3:0] hdr_bytes_reg;
    logic [3:0] len_pos_reg;
    logic [3:0] dir_pos_reg;
    logic [3:0] type_pos_reg;
    logic [7:0] status_code_reg;
    logic [7:0] control_code_reg;

    // Frame state
    logic [1:0] phase_reg,      phase_next;
    logic [3:0] hdr_idx_reg,    hdr_idx_next;
    logic [7:0] body_left_reg,  body_left_next;
    logic [7:0] len_seen_reg,   len_seen_next;
    logic [7:0] dir_seen_reg,   dir_seen_next;
    logic [7:0] type_seen_reg,  type_seen_next;
    logic [7:0] sum_st_reg,     sum_st_next;
    logic [7:0] sum_ct_reg,     sum_ct_next;

    // Result register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg,  out_item_next;

    logic       in_fire;
    logic       cfg_wr;
    logic [2:0] cfg_idx;
    logic [7:0] b;
    logic [3:0] hb;
    logic [3:0] cap_off;
    logic [7:0] cap_len;
    logic [7:0] cap_dir;
    logic [7:0] cap_type;
    logic [7:0] st_base;
    logic [7:0] ct_base;
    logic [7:0] st_upd;
    logic [7:0] ct_upd;
    logic [1:0] kind;
    logic [7:0] calc;

    // ------------------------------------------------------------------
    // APB configuration port: zero-wait writes at the access phase
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg       <= 8'd247;
            hdr_bytes_reg    <= 4'd6;
            len_pos_reg      <= 4'd5;
            dir_pos_reg      <= 4'd2;
            type_pos_reg     <= 4'd3;
            status_code_reg  <= 8'd80;
            control_code_reg <= 8'd15;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MARKER:    marker_reg       <= pwdata[7:0];
                REG_HDR_BYTES: hdr_bytes_reg    <= pwdata[3:0];
                REG_LEN_POS:   len_pos_reg      <= pwdata[3:0];
                REG_DIR_POS:   dir_pos_reg      <= pwdata[3:0];
                REG_TYPE_POS:  type_pos_reg     <= pwdata[3:0];
                REG_STATUS:    status_code_reg  <= pwdata[7:0];
                REG_CONTROL:   control_code_reg <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MARKER:    prdata = {24'd0, marker_reg};
            REG_HDR_BYTES: prdata = {28'd0, hdr_bytes_reg};
            REG_LEN_POS:   prdata = {28'd0, len_pos_reg};
            REG_DIR_POS:   prdata = {28'd0, dir_pos_reg};
            REG_TYPE_POS:  prdata = {28'd0, type_pos_reg};
            REG_STATUS:    prdata = {24'd0, status_code_reg};
            REG_CONTROL:   prdata = {24'd0, control_code_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes: only a checksum byte needs room in the result register
    // ------------------------------------------------------------------
    assign byte_in.ready = (phase_reg != PH_SUM) || !out_valid_reg || frame_out.ready;
    assign in_fire       = byte_in.valid && byte_in.ready;

    assign frame_out.valid   = out_valid_reg;
    assign frame_out.payload = out_item_reg;

    // ------------------------------------------------------------------
    // Per-byte step
    // ------------------------------------------------------------------
    assign b  = byte_in.payload.rx_byte;
    // A header shorter than two bytes acts as two
    assign hb = (hdr_bytes_reg < 4'd2) ? 4'd2 : hdr_bytes_reg;

    // In the hunt, a marker clears the captures and restarts both sums at
    // offset zero; in the header, capture at the running offset.
    always_comb
    begin
        if (phase_reg == PH_HUNT)
        begin
            cap_off = 4'd0;
            cap_len  = 8'd0;
            cap_dir  = 8'd0;
            cap_type = 8'd0;
            st_base  = SUM_INIT;
            ct_base  = SUM_INIT;
        end
        else
        begin
            cap_off = hdr_idx_reg;
            cap_len  = len_seen_reg;
            cap_dir  = dir_seen_reg;
            cap_type = type_seen_reg;
            st_base  = sum_st_reg;
            ct_base  = sum_ct_reg;
        end
    end

    assign st_upd = sum_step(st_base, SEED_STATUS, b);
    assign ct_upd = sum_step(ct_base, SEED_CONTROL, b);

    // Direction decides which sum is reported; equal codes favor status
    always_comb
    begin
        if (dir_seen_reg == status_code_reg)
        begin
            kind = KIND_STATUS;
            calc = sum_st_reg;
        end
        else if (dir_seen_reg == control_code_reg)
        begin
            kind = KIND_CONTROL;
            calc = sum_ct_reg;
        end
        else
        begin
            kind = KIND_UNKNOWN;
            calc = 8'd0;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        body_left_next = body_left_reg;
        len_seen_next  = len_seen_reg;
        dir_seen_next  = dir_seen_reg;
        type_seen_next = type_seen_reg;
        sum_st_next    = sum_st_reg;
        sum_ct_next    = sum_ct_reg;
        out_valid_next = out_valid_reg && !frame_out.ready;
        out_item_next  = out_item_reg;

        if (in_fire)
        begin
            case (phase_reg)
                PH_HUNT, PH_HEADER:
                begin
                    // Drop anything but the marker while hunting
                    if ((phase_reg == PH_HEADER) || (b == marker_reg))
                    begin
                        len_seen_next  = (cap_off == len_pos_reg)  ? b : cap_len;
                        dir_seen_next  = (cap_off == dir_pos_reg)  ? b : cap_dir;
                        type_seen_next = (cap_off == type_pos_reg) ? b : cap_type;
                        sum_st_next    = st_upd;
                        sum_ct_next    = ct_upd;
                        hdr_idx_next   = cap_off + 4'd1;
                        phase_next     = PH_HEADER;
                        // Header ends once the index reaches the header length
                        if (hdr_idx_next >= hb)
                        begin
                            body_left_next = len_seen_next;
                            phase_next     = (len_seen_next == 8'd0) ? PH_SUM : PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    sum_st_next    = st_upd;
                    sum_ct_next    = ct_upd;
                    body_left_next = body_left_reg - 8'd1;
                    if (body_left_next == 8'd0)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                default:
                begin
                    // Checksum byte: close the frame and load the result
                    out_valid_next            = 1'b1;
                    out_item_next.frame_kind  = kind;
                    out_item_next.frame_type  = type_seen_reg;
                    out_item_next.body_length = len_seen_reg;
                    out_item_next.calc_sum    = calc;
                    out_item_next.recv_sum    = b;
                    out_item_next.sum_ok      = (kind != KIND_UNKNOWN) && (calc == b);
                    phase_next                = PH_HUNT;
                    hdr_idx_next              = 4'd0;
                    body_left_next            = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            hdr_idx_reg   <= 4'd0;
            body_left_reg <= 8'd0;
            len_seen_reg  <= 8'd0;
            dir_seen_reg  <= 8'd0;
            type_seen_reg <= 8'd0;
            sum_st_reg    <= SUM_INIT;
            sum_ct_reg    <= SUM_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            body_left_reg <= body_left_next;
            len_seen_reg  <= len_seen_next;
            dir_seen_reg  <= dir_seen_next;
            type_seen_reg <= type_seen_next;
            sum_st_reg    <= sum_st_next;
            sum_ct_reg    <= sum_ct_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload holds no control state
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MFCC_ASSERT_NXT(a_sum_byte_gives_result, in_fire && (phase_reg == PH_SUM), out_valid_reg, "checksum byte transfer produced no result")
    `MFCC_ASSERT_IMP(a_no_result_overwrite, out_valid_reg && !frame_out.ready && in_fire, phase_reg != PH_SUM, "pending result would be overwritten")
    `MFCC_ASSERT_IMP(a_body_count_live, phase_reg == PH_BODY, body_left_reg != 8'd0, "body phase with empty body count")
    `MFCC_ASSERT_IMP(a_ok_needs_known_dir, out_valid_reg && out_item_reg.sum_ok, out_item_reg.frame_kind != KIND_UNKNOWN, "sum_ok set on unknown direction")

endmodule

[sim/marker_frame_checksum_checker_tb.sv]
// ----------------------------------------------------------------------------
// marker_frame_checksum_checker_tb
// Self-checking bench: streams marker-framed byte sequences into the checker,
// tracks the frame state and both running checksums alongside it, and checks
// every reported frame against the tracked result in transfer order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Tracks the checker's frame state, its registers and the frames still owed.
class frame_tracker;

    typedef enum logic [1:0] {SCAN_HUNT, SCAN_HEADER, SCAN_BODY, SCAN_SUM} scan_state_t;

    // register copies
    logic [7:0] marker_value;
    logic [3:0] header_bytes;
    logic [3:0] length_pos;
    logic [3:0] direction_pos;
    logic [3:0] type_pos;
    logic [7:0] status_code;
    logic [7:0] control_code;

    // frame state
    scan_state_t scan_state;
    logic [3:0]  header_index;
    logic [7:0]  body_left;
    logic [7:0]  length_seen;
    logic [7:0]  direction_seen;
    logic [7:0]  type_seen;
    logic [7:0]  status_sum;
    logic [7:0]  control_sum;

    mfcc_pkg::out_item_t pending_frames[$];
    int mismatches;
    int frames_seen;

    function new();
        marker_value   = 8'd247;
        header_bytes   = 4'd6;
        length_pos     = 4'd5;
        direction_pos  = 4'd2;
        type_pos       = 4'd3;
        status_code    = 8'd80;
        control_code   = 8'd15;
        scan_state     = SCAN_HUNT;
        header_index   = 4'd0;
        body_left      = 8'd0;
        length_seen    = 8'd0;
        direction_seen = 8'd0;
        type_seen      = 8'd0;
        status_sum     = mfcc_pkg::SUM_INIT;
        control_sum    = mfcc_pkg::SUM_INIT;
        mismatches     = 0;
        frames_seen    = 0;
    endfunction

    static function logic [7:0] fold(logic [7:0] acc, logic [7:0] seed, logic [7:0] b);
        return (acc << 1) ^ ({8{acc[7]}} & seed) ^ b;
    endfunction

    function bit hunting();
        return scan_state == SCAN_HUNT;
    endfunction

    function int outstanding();
        return pending_frames.size();
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
        case (idx)
            mfcc_pkg::REG_MARKER:    marker_value  = val;
            mfcc_pkg::REG_HDR_BYTES: header_bytes  = val[3:0];
            mfcc_pkg::REG_LEN_POS:   length_pos    = val[3:0];
            mfcc_pkg::REG_DIR_POS:   direction_pos = val[3:0];
            mfcc_pkg::REG_TYPE_POS:  type_pos      = val[3:0];
            mfcc_pkg::REG_STATUS:    status_code   = val;
            mfcc_pkg::REG_CONTROL:   control_code  = val;
            default: ;
        endcase
    endfunction

    function void capture(logic [3:0] offset, logic [7:0] b);
        if (offset == length_pos)
            length_seen = b;
        if (offset == direction_pos)
            direction_seen = b;
        if (offset == type_pos)
            type_seen = b;
    endfunction

    function void mix(logic [7:0] b);
        status_sum  = fold(status_sum, mfcc_pkg::SEED_STATUS, b);
        control_sum = fold(control_sum, mfcc_pkg::SEED_CONTROL, b);
    endfunction

    // A header shorter than two bytes still spans the marker and one byte.
    function void header_check();
        int hb;
        hb = (header_bytes < 2) ? 2 : header_bytes;
        if (header_index >= hb)
        begin
            body_left  = length_seen;
            scan_state = (body_left == 0) ? SCAN_SUM : SCAN_BODY;
        end
    endfunction

    // Advance on one accepted byte; returns 0 when the byte is dropped while hunting.
    function bit take_byte(logic [7:0] b);
        mfcc_pkg::out_item_t want;
        case (scan_state)
            SCAN_HUNT:
            begin
                if (b != marker_value)
                    return 1'b0;
                length_seen    = 8'd0;
                direction_seen = 8'd0;
                type_seen      = 8'd0;
                status_sum     = mfcc_pkg::SUM_INIT;
                control_sum    = mfcc_pkg::SUM_INIT;
                capture(4'd0, b);
                mix(b);
                header_index = 4'd1;
                scan_state   = SCAN_HEADER;
                header_check();
            end
            SCAN_HEADER:
            begin
                capture(header_index, b);
                mix(b);
                header_index = header_index + 4'd1;
                header_check();
            end
            SCAN_BODY:
            begin
                mix(b);
                body_left = body_left - 8'd1;
                if (body_left == 0)
                    scan_state = SCAN_SUM;
            end
            default:
            begin
                if (direction_seen == status_code)
                begin
                    want.frame_kind = mfcc_pkg::KIND_STATUS;
                    want.calc_sum   = status_sum;
                end
                else if (direction_seen == control_code)
                begin
                    want.frame_kind = mfcc_pkg::KIND_CONTROL;
                    want.calc_sum   = control_sum;
                end
                else
                begin
                    want.frame_kind = mfcc_pkg::KIND_UNKNOWN;
                    want.calc_sum   = 8'h00;
                end
                want.frame_type  = type_seen;
                want.body_length = length_seen;
                want.recv_sum    = b;
                want.sum_ok      = (want.frame_kind != mfcc_pkg::KIND_UNKNOWN) &&
                                   (want.calc_sum == b);
                pending_frames.push_back(want);
                scan_state   = SCAN_HUNT;
                header_index = 4'd0;
                body_left    = 8'd0;
            end
        endcase
        return 1'b1;
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task match_frame(mfcc_pkg::out_item_t got);
        mfcc_pkg::out_item_t want;
        frames_seen++;
        if (pending_frames.size() == 0)
        begin
            report($sformatf("frame %0d arrived with none owed: kind=%0d type=%02h len=%0d",
                             frames_seen, got.frame_kind, got.frame_type, got.body_length));
            return;
        end
        want = pending_frames.pop_front();
        if (got !== want)
            report($sformatf({"frame %0d got kind=%0d type=%02h len=%0d calc=%02h recv=%02h",
                              " ok=%0b, want kind=%0d type=%02h len=%0d calc=%02h recv=%02h ok=%0b"},
                             frames_seen, got.frame_kind, got.frame_type, got.body_length,
                             got.calc_sum, got.recv_sum, got.sum_ok, want.frame_kind,
                             want.frame_type, want.body_length, want.calc_sum, want.recv_sum,
                             want.sum_ok));
    endtask

    task close_out();
        if (pending_frames.size() != 0)
            report($sformatf("%0d frame(s) never reported", pending_frames.size()));
    endtask

endclass

module marker_frame_checksum_checker_tb;
    import mfcc_pkg::*;

    // Settle time after the last owed frame: result latency plus margin.
    localparam int SETTLE_CYCLES   = 4;
    // Long receiver hold-off; long enough to back the checker up on a checksum byte.
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASE_ITEMS     = 165;
    localparam int NUM_PHASES      = 8;
    localparam int LIMIT_CYCLES    = 400000;

    typedef struct {
        logic [7:0] marker;
        logic [3:0] hdr_len;
        logic [3:0] len_pos;
        logic [3:0] dir_pos;
        logic [3:0] type_pos;
        logic [7:0] status;
        logic [7:0] control;
    } frame_cfg_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mfcc_in_if  rx_ch ();
    mfcc_out_if frame_ch ();

    marker_frame_checksum_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .byte_in   (rx_ch),
        .frame_out (frame_ch)
    );

    frame_tracker frames = new();

    int send_idle_pct;
    int recv_idle_pct;
    int items_taken;
    int hold_asked;
    int hold_done;
    int cycle_count;

    // ------------------------------------------------------------------------
    // Clock: 2 ns period.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run as failed once the cycle limit is reached.
    // ------------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("marker_frame_checksum_checker verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Frame receiver: random back-pressure, plus a long hold-off whenever the
    // stimulus asks for one. The hold is counted here, so the sender keeps
    // offering bytes and the checker backs up on its next checksum byte.
    // ------------------------------------------------------------------------
    initial
    begin
        frame_ch.ready = 1'b0;
        hold_done      = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_asked)
            begin
                hold_done = hold_asked;
                frame_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                frame_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check every frame transfer against the oldest owed frame.
    // Sampled at the edge, so values are the ones the transfer used.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && frame_ch.valid && frame_ch.ready)
            frames.match_frame(frame_ch.payload);
    end

    // ------------------------------------------------------------------------
    // Byte driver: idle at random, then hold valid until the transfer. The
    // tracker advances here, at the edge that took the byte, so the frame
    // builder always sees the state that follows the last transfer.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid           <= 1'b1;
        rx_ch.payload.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        items_taken += frames.take_byte(b);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic reg_write(input logic [2:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frames.set_reg(idx, val);
    endtask

    task automatic apply_cfg(input frame_cfg_t c);
        reg_write(REG_MARKER,    c.marker);
        reg_write(REG_HDR_BYTES, {4'd0, c.hdr_len});
        reg_write(REG_LEN_POS,   {4'd0, c.len_pos});
        reg_write(REG_DIR_POS,   {4'd0, c.dir_pos});
        reg_write(REG_TYPE_POS,  {4'd0, c.type_pos});
        reg_write(REG_STATUS,    c.status);
        reg_write(REG_CONTROL,   c.control);
    endtask

    // Drop valid, wait for every owed frame, then let the last byte settle.
    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (frames.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Frame builder. dir_sel picks a status, control or unknown direction;
    // fill < 0 means random header filler and body, else every filler byte is
    // fill. cut >= 0 stops after that many bytes to leave a broken frame.
    // The captured fields are read back from the built header, so overlapping
    // or out-of-header positions come out the way the checker sees them.
    // ------------------------------------------------------------------------
    task automatic send_frame(input int dir_sel, input int body_len, input bit good_sum,
                              input int cut, input int fill);
        logic [7:0] hdr [0:15];
        logic [7:0] frame_bytes [$];
        logic [7:0] dir_byte;
        logic [7:0] len_byte;
        logic [7:0] st_acc;
        logic [7:0] ct_acc;
        logic [7:0] calc;
        int         hb;

        // Flush any broken frame with small bytes so the body stays short.
        while (!frames.hunting())
            send_byte(8'($urandom_range(0, 15)));

        hb = (frames.header_bytes < 2) ? 2 : frames.header_bytes;
        for (int i = 0; i < 16; i++)
            hdr[i] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);

        if (dir_sel == KIND_STATUS)
            dir_byte = frames.status_code;
        else if (dir_sel == KIND_CONTROL)
            dir_byte = frames.control_code;
        else
        begin
            dir_byte = 8'($urandom_range(0, 255));
            while (dir_byte == frames.status_code || dir_byte == frames.control_code)
                dir_byte = 8'($urandom_range(0, 255));
        end

        if (frames.direction_pos != 0 && frames.direction_pos < hb)
            hdr[frames.direction_pos] = dir_byte;
        if (frames.length_pos != 0 && frames.length_pos < hb)
            hdr[frames.length_pos] = 8'(body_len);
        hdr[0] = frames.marker_value;

        len_byte = (frames.length_pos < hb) ? hdr[frames.length_pos] : 8'h00;
        dir_byte = (frames.direction_pos < hb) ? hdr[frames.direction_pos] : 8'h00;

        for (int i = 0; i < hb; i++)
            frame_bytes.push_back(hdr[i]);
        for (int i = 0; i < len_byte; i++)
            frame_bytes.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));

        st_acc = SUM_INIT;
        ct_acc = SUM_INIT;
        foreach (frame_bytes[i])
        begin
            st_acc = frames.fold(st_acc, SEED_STATUS, frame_bytes[i]);
            ct_acc = frames.fold(ct_acc, SEED_CONTROL, frame_bytes[i]);
        end
        if (dir_byte == frames.status_code)
            calc = st_acc;
        else if (dir_byte == frames.control_code)
            calc = ct_acc;
        else
            calc = 8'h00;
        frame_bytes.push_back(good_sum ? calc : calc ^ 8'($urandom_range(1, 255)));

        foreach (frame_bytes[i])
        begin
            if (cut < 0 || i < cut)
                send_byte(frame_bytes[i]);
        end
    endtask

    function automatic frame_cfg_t random_cfg();
        frame_cfg_t c;
        c.marker   = 8'($urandom_range(0, 255));
        c.hdr_len  = 4'($urandom_range(3, 15));
        c.len_pos  = 4'($urandom_range(1, c.hdr_len - 1));
        c.dir_pos  = 4'($urandom_range(1, c.hdr_len - 1));
        c.type_pos = 4'($urandom_range(1, c.hdr_len - 1));
        c.status   = 8'($urandom_range(0, 255));
        c.control  = 8'($urandom_range(0, 255));
        while (c.control == c.status)
            c.control = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    frame_cfg_t phase_cfg [NUM_PHASES];

    initial
    begin
        int target;
        int pick;
        int body_len;

        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        rx_ch.valid           = 1'b0;
        rx_ch.payload.rx_byte = 8'h00;
        items_taken           = 0;
        hold_asked            = 0;
        send_idle_pct         = 37;
        recv_idle_pct         = 53;

        // Minimal header; direction and type sit outside it, so every frame
        // reads direction 0, which is the status code here.
        phase_cfg[0] = '{8'h00, 4'd2, 4'd1, 4'd15, 4'd14, 8'h00, 8'hFF};
        // Longest header, extreme codes and marker.
        phase_cfg[1] = '{8'hFF, 4'd15, 4'd14, 4'd13, 4'd1, 8'hFF, 8'h00};
        // Header length 0 acts as 2; direction and type capture the marker.
        phase_cfg[2] = '{8'hA5, 4'd0, 4'd1, 4'd0, 4'd0, 8'hA5, 8'h5A};
        // Equal codes: control frames report as status.
        phase_cfg[3] = '{8'h7E, 4'd8, 4'd7, 4'd3, 4'd5, 8'h33, 8'h33};
        // Header length 1 acts as 2; length taken from the marker itself.
        phase_cfg[4] = '{8'h03, 4'd1, 4'd0, 4'd1, 4'd1, 8'h10, 8'h20};
        phase_cfg[5] = random_cfg();
        phase_cfg[6] = random_cfg();
        phase_cfg[7] = random_cfg();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --------------------------------------------------------------------
        // Directed part, reset register values.
        // --------------------------------------------------------------------
        // Drop non-marker bytes while hunting.
        send_byte(8'h00);
        send_byte(8'hFF);
        // Status frame, empty body, good checksum.
        send_frame(KIND_STATUS, 0, 1'b1, -1, 8'h00);
        // Control frame with the marker value inside header and body.
        send_frame(KIND_CONTROL, 1, 1'b1, -1, 8'hF7);
        // Unknown direction: frame is consumed and reported as unknown, never sum_ok.
        send_frame(KIND_UNKNOWN, 0, 1'b0, -1, 8'hFF);
        // Shrink the header in the middle of a frame: the next header byte ends
        // it, and the byte after that is the checksum.
        send_frame(KIND_STATUS, 4, 1'b1, 3, -1);
        settle();
        reg_write(REG_HDR_BYTES, 8'd2);
        send_byte(8'h00);
        send_byte(8'hA5);
        settle();

        // --------------------------------------------------------------------
        // Random phases: mostly well-formed frames with random content, the
        // rest broken frames and noise. Idle pattern changes every group.
        // --------------------------------------------------------------------
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            apply_cfg(phase_cfg[p]);
            if (p == 0 || p == 3 || p == 6)
            begin
                send_idle_pct = (p == 0) ? 37 : (p == 3) ? 53 : 0;
                recv_idle_pct = (p == 0) ? 53 : (p == 3) ? 37 : 0;
                hold_asked++;
            end
            target = items_taken + PHASE_ITEMS;
            while (items_taken < target)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 149) == 0)
                    body_len = 255;
                else if ($urandom_range(0, 19) == 0)
                    body_len = $urandom_range(9, 40);
                else
                    body_len = $urandom_range(0, 8);
                if (pick < 75)
                    send_frame($urandom_range(0, 2), body_len, $urandom_range(0, 3) != 0,
                               -1, -1);
                else if (pick < 88)
                    send_frame($urandom_range(0, 2), body_len, 1'b1,
                               $urandom_range(1, 6), -1);
                else
                begin
                    repeat ($urandom_range(1, 5))
                        send_byte(8'($urandom_range(0, 255)));
                end
            end
            settle();
        end

        frames.close_out();
        if (frames.mismatches == 0)
            $display("marker_frame_checksum_checker verification clean");
        else
            $display("marker_frame_checksum_checker verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/mfcc_pkg.sv
src/mfcc_if.sv
src/marker_frame_checksum_checker.sv
sim/marker_frame_checksum_checker_tb.sv
